// ----- design/fdis_pkg.sv -----
package fdis_pkg;

    localparam int QUERIES_DEF    = 96;
    localparam int CANDIDATES_DEF = 256;

    localparam int IDX_W     = 31;
    localparam int LANE_W    = 64;
    localparam int ORDINAL_W = 8;
    localparam int DB_W      = 5;

    localparam logic [DB_W-1:0]   DOM_WIDTH_RESET     = 5'd10;
    localparam logic [DB_W-1:0]   MIN_DOM_WIDTH       = 5'd7;
    localparam logic [LANE_W-1:0] FIELD_MODULUS_RESET = 64'hFFFF_FFFF_0000_0001;

    typedef enum logic
    {
        REG_DOM_WIDTH     = 1'b0,
        REG_FIELD_MODULUS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_BAD_SHAPE = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

    typedef struct packed
    {
        logic [IDX_W-1:0] idx;
        logic             noncanon;
        logic             domain_bad;
        logic             last;
    } cand_t;

    typedef struct packed
    {
        logic                 selected;
        logic [IDX_W-1:0]     index;
        logic [ORDINAL_W-1:0] ordinal;
        logic                 done_res;
        status_t              status;
    } result_t;

endpackage

// ----- design/first_distinct_index_selector.sv -----
// The back end passes through its idle and emit states on an item that needs no search,
// and through idle, scan and emit when it scans the index store, one entry per cycle; emit
// waits while the output queue is full. It holds one item at a time and does not take a
// new item until it has emitted the last one. Two-entry queues sit on both sides of the
// back end. Reset is asynchronous and active low; it clears the run state and reloads the
// index width to 10 and the modulus to 0xFFFFFFFF00000001, not the index store.
module first_distinct_index_selector #(
    parameter int QUERIES    = fdis_pkg::QUERIES_DEF,
    parameter int CANDIDATES = fdis_pkg::CANDIDATES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [fdis_pkg::LANE_W-1:0]       lane_zero,
    input  logic [fdis_pkg::LANE_W-1:0]       lane_one,
    input  logic [fdis_pkg::LANE_W-1:0]       lane_two,
    input  logic                              last_candidate,
    output logic                              empty,
    input  logic                              pop,
    output logic                              selected,
    output logic [fdis_pkg::IDX_W-1:0]        index,
    output logic [fdis_pkg::ORDINAL_W-1:0]    ordinal,
    output logic                              done_res,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [fdis_pkg::LANE_W-1:0]       cfg_data
);

    import fdis_pkg::*;

    cand_t   front_cand;
    logic    front_push;
    logic    mid_full;
    cand_t   mid_cand;
    logic    mid_empty;
    logic    mid_pop;
    result_t back_res;
    logic    back_push;
    logic    out_full;
    result_t out_res;

    fdis_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .lane_zero      (lane_zero),
        .lane_one       (lane_one),
        .lane_two       (lane_two),
        .last_candidate (last_candidate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cand           (front_cand),
        .cand_push      (front_push),
        .cand_full      (mid_full)
    );

    fdis_fifo #(
        .WIDTH ($bits(cand_t)),
        .DEPTH (2)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cand),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_cand),
        .empty (mid_empty)
    );

    fdis_back #(
        .QUERIES    (QUERIES),
        .CANDIDATES (CANDIDATES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand       (mid_cand),
        .cand_valid (!mid_empty),
        .cand_pop   (mid_pop),
        .res        (back_res),
        .res_push   (back_push),
        .res_full   (out_full)
    );

    fdis_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign selected = out_res.selected;
    assign index    = out_res.index;
    assign ordinal  = out_res.ordinal;
    assign done_res = out_res.done_res;
    assign status   = out_res.status;

endmodule

// ----- design/fdis_ram.sv -----
module fdis_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/fdis_fifo.sv -----
module fdis_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    wptr_next;
    logic [PW-1:0]    rptr_reg;
    logic [PW-1:0]    rptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/fdis_front.sv -----
module fdis_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [fdis_pkg::LANE_W-1:0]   lane_zero,
    input  logic [fdis_pkg::LANE_W-1:0]   lane_one,
    input  logic [fdis_pkg::LANE_W-1:0]   lane_two,
    input  logic                          last_candidate,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [fdis_pkg::LANE_W-1:0]   cfg_data,
    output fdis_pkg::cand_t               cand,
    output logic                          cand_push,
    input  logic                          cand_full
);

    import fdis_pkg::*;

    logic [DB_W-1:0]   dom_width_reg;
    logic [DB_W-1:0]   dom_width_next;
    logic [LANE_W-1:0] modulus_reg;
    logic [LANE_W-1:0] modulus_next;
    logic [IDX_W-1:0]  idx_mask;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        dom_width_next = dom_width_reg;
        modulus_next   = modulus_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DOM_WIDTH:     dom_width_next = cfg_data[DB_W-1:0];
                REG_FIELD_MODULUS: modulus_next   = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dom_width_reg <= DOM_WIDTH_RESET;
            modulus_reg   <= FIELD_MODULUS_RESET;
        end
        else
        begin
            dom_width_reg <= dom_width_next;
            modulus_reg   <= modulus_next;
        end
    end

    // The mask keeps the low dom_width_reg bits; a shift of 31 leaves all ones.
    assign idx_mask = ~({IDX_W{1'b1}} << dom_width_reg);

    assign full      = cand_full;
    assign cand_push = push && !cand_full;

    always_comb
    begin
        cand.idx        = lane_zero[IDX_W-1:0] & idx_mask;
        cand.noncanon   = (lane_zero >= modulus_reg) || (lane_one >= modulus_reg)
                          || (lane_two >= modulus_reg);
        cand.domain_bad = (dom_width_reg < MIN_DOM_WIDTH);
        cand.last       = last_candidate;
    end

endmodule

// ----- design/fdis_back.sv -----
module fdis_back #(
    parameter int QUERIES    = fdis_pkg::QUERIES_DEF,
    parameter int CANDIDATES = fdis_pkg::CANDIDATES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdis_pkg::cand_t   cand,
    input  logic              cand_valid,
    output logic              cand_pop,
    output fdis_pkg::result_t res,
    output logic              res_push,
    input  logic              res_full
);

    import fdis_pkg::*;

    localparam int SW = $clog2(QUERIES + 1);
    localparam int AW = (QUERIES > 1) ? $clog2(QUERIES) : 1;
    localparam int CW = $clog2(CANDIDATES + 1);
    localparam logic [SW-1:0] QUERIES_C    = SW'(QUERIES);
    localparam logic [CW-1:0] CANDIDATES_C = CW'(CANDIDATES);

    back_state_t  state_reg;
    back_state_t  state_next;
    logic [SW-1:0] sel_total_reg;
    logic [SW-1:0] sel_total_next;
    logic [CW-1:0] cand_total_reg;
    logic [CW-1:0] cand_total_next;
    logic          shape_err_reg;
    logic          shape_err_next;
    logic [SW-1:0] ptr_reg;
    logic [SW-1:0] ptr_next;
    logic          cmp_valid_reg;
    logic          cmp_valid_next;
    logic          hit_reg;
    logic          hit_next;

    logic             in_range;
    logic             room;
    logic             match;
    logic             scan_end;
    logic             sel;
    logic             shape_now;
    logic [SW-1:0]    sel_count;
    logic [CW-1:0]    cand_count;
    logic [CW+ORDINAL_W-1:0] ordinal_wide;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_rd_data;

    fdis_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUERIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (sel_total_reg[AW-1:0]),
        .wr_data (cand.idx),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign in_range  = (cand_total_reg != CANDIDATES_C);
    assign room      = (sel_total_reg != QUERIES_C);
    assign match     = cmp_valid_reg && (ram_rd_data == cand.idx);
    assign scan_end  = match || ((ptr_reg == sel_total_reg) && !cmp_valid_reg);
    assign sel       = in_range && room && !hit_reg;
    assign shape_now = shape_err_reg || cand.noncanon || cand.domain_bad || !in_range;
    assign sel_count  = sel_total_reg + SW'(sel);
    assign cand_count = cand_total_reg + CW'(in_range);
    assign ordinal_wide = {{ORDINAL_W{1'b0}}, cand_total_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cand_valid)
                begin
                    if (in_range && room && (sel_total_reg != '0))
                    begin
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        sel_total_next  = sel_total_reg;
        cand_total_next = cand_total_reg;
        shape_err_next  = shape_err_reg;
        ptr_next        = ptr_reg;
        cmp_valid_next  = cmp_valid_reg;
        hit_next        = hit_reg;
        ram_wr_en       = 1'b0;
        cand_pop        = 1'b0;
        res_push        = 1'b0;

        res.selected = sel;
        res.index    = cand.idx;
        res.ordinal  = ordinal_wide[ORDINAL_W-1:0];
        res.done_res = cand.last;
        res.status   = STATUS_OK;
        if (cand.last)
        begin
            if (shape_now || (cand_count != CANDIDATES_C))
            begin
                res.status = STATUS_BAD_SHAPE;
            end
            else if (sel_count < QUERIES_C)
            begin
                res.status = STATUS_EXHAUSTED;
            end
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                ptr_next       = '0;
                cmp_valid_next = 1'b0;
                hit_next       = 1'b0;
            end
            BK_SCAN:
            begin
                // Address issued this cycle is compared in the next one.
                cmp_valid_next = (ptr_reg != sel_total_reg) && !match;
                if (ptr_reg != sel_total_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (match)
                begin
                    hit_next = 1'b1;
                end
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    res_push  = 1'b1;
                    cand_pop  = 1'b1;
                    ram_wr_en = sel;
                    if (cand.last)
                    begin
                        sel_total_next  = '0;
                        cand_total_next = '0;
                        shape_err_next  = 1'b0;
                    end
                    else
                    begin
                        sel_total_next  = sel_count;
                        cand_total_next = cand_count;
                        shape_err_next  = shape_now;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            sel_total_reg  <= '0;
            cand_total_reg <= '0;
            shape_err_reg  <= 1'b0;
            ptr_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_total_reg  <= sel_total_next;
            cand_total_reg <= cand_total_next;
            shape_err_reg  <= shape_err_next;
            ptr_reg        <= ptr_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_reg        <= hit_next;
        end
    end

endmodule

// ----- test/tb.sv -----
module tb;
    import fdis_pkg::*;

    localparam int unsigned ITEM_TARGET = 1300;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    class selection_tracker;
        logic [DB_W-1:0]   dom_bits;
        logic [LANE_W-1:0] modulus;
        logic [IDX_W-1:0]  held_idx [QUERIES_DEF];
        int unsigned       held_total;
        int unsigned       cand_total;
        bit                shape_bad;
        result_t           outcomes_due [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       closed [3];

        function new();
            dom_bits = DOM_WIDTH_RESET;
            modulus = FIELD_MODULUS_RESET;
            errors = 0;
            checked = 0;
            foreach (closed[i])
                closed[i] = 0;
            clear_run();
        endfunction

        function void clear_run();
            held_total = 0;
            cand_total = 0;
            shape_bad = 1'b0;
        endfunction

        function void set_register(reg_index_t which, logic [LANE_W-1:0] value);
            if (which == REG_DOM_WIDTH)
                dom_bits = value[DB_W-1:0];
            else
                modulus = value;
        endfunction

        // Works out the result of one accepted candidate and queues it.
        function void note_candidate(logic [LANE_W-1:0] l0, logic [LANE_W-1:0] l1,
                                     logic [LANE_W-1:0] l2, logic last);
            logic [LANE_W-1:0] mask;
            logic [IDX_W-1:0]  idx;
            result_t           r;
            bit                seen;
            int unsigned       i;
            mask = (64'd1 << dom_bits) - 64'd1;
            idx = IDX_W'(l0 & mask);
            seen = 1'b0;
            r = '0;
            r.index = idx;
            r.ordinal = ORDINAL_W'(cand_total);
            r.done_res = last;
            if (l0 >= modulus || l1 >= modulus || l2 >= modulus || dom_bits < MIN_DOM_WIDTH)
                shape_bad = 1'b1;
            if (cand_total >= CANDIDATES_DEF)
            begin
                shape_bad = 1'b1;
            end
            else
            begin
                for (i = 0; i < held_total; i++)
                begin
                    if (held_idx[i] == idx)
                        seen = 1'b1;
                end
                if (held_total < QUERIES_DEF && !seen)
                begin
                    held_idx[held_total] = idx;
                    held_total++;
                    r.selected = 1'b1;
                end
                cand_total++;
            end
            if (last)
            begin
                if (shape_bad || cand_total != CANDIDATES_DEF)
                    r.status = STATUS_BAD_SHAPE;
                else if (held_total < QUERIES_DEF)
                    r.status = STATUS_EXHAUSTED;
                else
                    r.status = STATUS_OK;
                clear_run();
            end
            outcomes_due.insert(outcomes_due.size(), r);
        endfunction

        function void compare_field(string name, logic [LANE_W-1:0] want,
                                    logic [LANE_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(result_t got);
            result_t want;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result with none expected, actual index %0h ordinal %0d",
                         $time, got.index, got.ordinal);
                errors++;
                return;
            end
            want = outcomes_due.pop_front();
            checked++;
            compare_field("selected", LANE_W'(want.selected), LANE_W'(got.selected));
            compare_field("index", LANE_W'(want.index), LANE_W'(got.index));
            compare_field("ordinal", LANE_W'(want.ordinal), LANE_W'(got.ordinal));
            compare_field("done_res", LANE_W'(want.done_res), LANE_W'(got.done_res));
            compare_field("status", LANE_W'(want.status), LANE_W'(got.status));
            if (want.done_res)
                closed[want.status]++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [LANE_W-1:0]    lane_zero = '0;
    logic [LANE_W-1:0]    lane_one = '0;
    logic [LANE_W-1:0]    lane_two = '0;
    logic                 last_candidate = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 selected;
    logic [IDX_W-1:0]     index;
    logic [ORDINAL_W-1:0] ordinal;
    logic                 done_res;
    logic [1:0]           status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    reg_index_t           cfg_index = REG_DOM_WIDTH;
    logic [LANE_W-1:0]    cfg_data = '0;

    selection_tracker sb = new();
    result_t          seen_out;
    int unsigned      sent = 0;
    int unsigned      burst_left = 0;
    int unsigned      cycles = 0;

    first_distinct_index_selector uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .lane_zero      (lane_zero),
        .lane_one       (lane_one),
        .lane_two       (lane_two),
        .last_candidate (last_candidate),
        .empty          (empty),
        .pop            (pop),
        .selected       (selected),
        .index          (index),
        .ordinal        (ordinal),
        .done_res       (done_res),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                seen_out.selected = selected;
                seen_out.index = index;
                seen_out.ordinal = ordinal;
                seen_out.done_res = done_res;
                seen_out.status = status_t'(status);
                sb.check_outcome(seen_out);
            end
            if (push && !full)
                sb.note_candidate(lane_zero, lane_one, lane_two, last_candidate);
        end
    end

    initial
    begin
        int unsigned stall_left;
        int unsigned steady_left;
        int unsigned r;
        stall_left = 0;
        steady_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady_left > 0)
            begin
                steady_left--;
                pop = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 999);
                pop = 1'b1;
                if (r < 5)
                    steady_left = $urandom_range(100, 400);
                else if (r < 20)
                    stall_left = $urandom_range(20, 80);
                else if (r < 250)
                    stall_left = $urandom_range(0, 3);
            end
        end
    end

    task automatic send_candidate(logic [LANE_W-1:0] l0, logic [LANE_W-1:0] l1,
                                  logic [LANE_W-1:0] l2, logic last);
        int unsigned r;
        int unsigned gap;
        @(negedge clk);
        push = 1'b1;
        lane_zero = l0;
        lane_one = l1;
        lane_two = l2;
        last_candidate = last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                burst_left = $urandom_range(30, 150);
            else if (r >= 70 && r < 95)
                gap = $urandom_range(1, 4);
            else if (r >= 95)
                gap = $urandom_range(15, 70);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (sb.outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(reg_index_t which, logic [LANE_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = which;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(which, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [LANE_W-1:0] make_lane(bit canon);
        logic [LANE_W-1:0] v;
        logic [LANE_W-1:0] m;
        m = sb.modulus;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
            v = (canon && m != 0) ? m - 64'd1 : m;
        else if (canon && m != 0 && v >= m)
            v = v % m;
        else if (!canon && v < m)
            v = m + (v & ~m);
        return v;
    endfunction

    initial
    begin
        logic [LANE_W-1:0] l0;
        logic [LANE_W-1:0] mask;
        logic [LANE_W-1:0] data;
        logic [IDX_W-1:0]  pool [QUERIES_DEF];
        int unsigned       pool_size;
        int unsigned       kind;
        int unsigned       n;
        int unsigned       i;
        int unsigned       pause_at;
        bit                noisy;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: lanes at and around the modulus, a repeated index.
        send_candidate(64'd0, 64'd0, 64'd0, 1'b0);
        send_candidate(FIELD_MODULUS_RESET - 64'd1, FIELD_MODULUS_RESET - 64'd1, 64'd0, 1'b0);
        send_candidate('1, 64'd0, 64'd0, 1'b0);
        send_candidate(64'd0, FIELD_MODULUS_RESET, '1, 1'b0);
        send_candidate(64'h3FF, 64'd0, FIELD_MODULUS_RESET, 1'b1);
        wait_drained();

        // Widest index and largest modulus.
        write_register(REG_DOM_WIDTH, '1);
        write_register(REG_FIELD_MODULUS, '1);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_AAAA_5555_AAAA,
                       1'b0);
        send_candidate(64'h8000_0000_7FFF_FFFF, 64'hAAAA_5555_AAAA_5555, 64'd0, 1'b0);
        send_candidate(64'h0000_0000_7FFF_FFFF, '1, 64'd1, 1'b1);
        wait_drained();

        // A domain that is too small, and a modulus that no lane can satisfy.
        write_register(REG_DOM_WIDTH, 64'd0);
        write_register(REG_FIELD_MODULUS, 64'd0);
        send_candidate(64'd0, 64'd0, 64'd0, 1'b0);
        send_candidate('1, '1, '1, 1'b1);
        wait_drained();

        write_register(REG_DOM_WIDTH, 64'hFFFF_FFFF_FFFF_FFE6);
        write_register(REG_FIELD_MODULUS, FIELD_MODULUS_RESET);
        send_candidate(64'h3F, 64'd5, 64'd7, 1'b0);
        send_candidate(64'h40, 64'd5, 64'd7, 1'b1);
        wait_drained();
        write_register(REG_DOM_WIDTH, 64'd7);

        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                data = {$urandom, $urandom};
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    data[DB_W-1:0] = DB_W'($urandom_range(0, 6));
                else if (kind == 1)
                    data[DB_W-1:0] = 5'd31;
                else if (kind == 2)
                    data[DB_W-1:0] = 5'd7;
                else
                    data[DB_W-1:0] = DB_W'($urandom_range(7, 31));
                write_register(REG_DOM_WIDTH, data);
                kind = $urandom_range(0, 9);
                if (kind == 6)
                    data = '1;
                else if (kind == 7)
                    data = {$urandom, $urandom};
                else if (kind == 8)
                    data = {1'b1, 31'($urandom), 32'($urandom)};
                else if (kind == 9)
                    data = LANE_W'($urandom_range(1, 1000));
                else
                    data = FIELD_MODULUS_RESET;
                write_register(REG_FIELD_MODULUS, data);
            end

            // Most runs are full length; some reuse a small index set, some are cut
            // short, and some overrun the candidate limit.
            kind = $urandom_range(0, 9);
            if (kind < 8)
                n = CANDIDATES_DEF;
            else if (kind == 8)
                n = $urandom_range(1, 40);
            else
                n = CANDIDATES_DEF + $urandom_range(1, 6);
            pool_size = (kind == 6 || kind == 7) ? $urandom_range(1, QUERIES_DEF - 1) : 0;
            for (i = 0; i < pool_size; i++)
                pool[i] = IDX_W'($urandom);
            noisy = ($urandom_range(0, 7) == 0);
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
            mask = (64'd1 << sb.dom_bits) - 64'd1;
            for (i = 1; i <= n; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                l0 = make_lane(!noisy || $urandom_range(0, 29) != 0);
                if (pool_size > 0)
                    l0 = (l0 & ~mask) | (LANE_W'(pool[$urandom_range(0, pool_size - 1)]) & mask);
                send_candidate(l0, make_lane(!noisy || $urandom_range(0, 29) != 0),
                               make_lane(!noisy || $urandom_range(0, 29) != 0), i == n);
            end
        end

        wait_drained();
        repeat (2 * (QUERIES_DEF + 8))
            @(posedge clk);
        $display("tb: %0d candidates sent, %0d results checked", sent, sb.checked);
        $display("tb: runs closed as ok %0d, exhausted %0d, bad shape %0d",
                 sb.closed[STATUS_OK], sb.closed[STATUS_EXHAUSTED], sb.closed[STATUS_BAD_SHAPE]);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
